// ----- rtl/core/egd_pkg.sv -----
// ----------------------------------------------------------------------------
// egd_pkg
// Shared types, codes and defaults for the lift group dispatcher.
// ----------------------------------------------------------------------------
package egd_pkg;

    localparam int FLOORS_DEF     = 16;
    localparam int CARS_DEF       = 4;
    localparam int STAMP_BITS_DEF = 16;

    localparam int FUNC_W  = 2;
    localparam int CAR_W   = 2;
    localparam int FLOOR_W = 4;

    localparam logic [FUNC_W-1:0] FUNC_BUTTON = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_HALL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CAR_W-1:0]   car_index;
        logic [FLOOR_W-1:0] floor;
    } t_in_item;

    typedef struct packed {
        logic [CAR_W-1:0]   car_id;
        logic [FLOOR_W-1:0] car_floor;
        logic [FLOOR_W-1:0] car_target;
        logic               door_is_open;
        logic               last_car;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic do_button;
        logic do_hall;
        logic clr_doors;
        logic serve;     // phase 1 on current car
        logic aim_init;  // phase 2 start for current car
        logic aim_step;  // one distance step
        logic scan_init; // phase 3 start oldest scan
        logic scan_step; // one floor of scan
        logic assign_c;  // take scan result for current car
        logic move;      // phase 4 on current car
        logic emit;      // result for current car
        logic car_next;
        logic car_clr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       is_button;
        logic       is_hall;
        logic       is_step;
        logic       car_last;
        logic       at_target;
        logic       aim_done;
        logic       scan_done;
        logic       found;
    } t_sts;

endpackage

// ----- rtl/core/egd_datapath.sv -----
// ----------------------------------------------------------------------------
// egd_datapath
// Car state, buttons, hall stamps and the scan units for the dispatcher.
// ----------------------------------------------------------------------------
module egd_datapath #(
    parameter int FLOORS     = egd_pkg::FLOORS_DEF,
    parameter int CARS       = egd_pkg::CARS_DEF,
    parameter int STAMP_BITS = egd_pkg::STAMP_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  egd_pkg::t_in_item i_item,
    input  egd_pkg::t_cmd     i_cmd,
    output egd_pkg::t_sts     o_sts,
    output egd_pkg::t_out_item o_result
);
    localparam int FW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;
    localparam int DW = $clog2(FLOORS + 1);
    localparam logic [STAMP_BITS-1:0] SMAX = {STAMP_BITS{1'b1}};

    logic [FW-1:0]         r_floor  [CARS];
    logic [FW-1:0]         r_target [CARS];
    logic [CARS-1:0]       r_door;
    logic [FLOORS-1:0]     r_btn    [CARS];
    logic [STAMP_BITS-1:0] r_stamp  [FLOORS];
    logic [STAMP_BITS-1:0] r_cnt;
    egd_pkg::t_in_item     r_item;
    logic [CW-1:0]         r_car;
    logic [DW-1:0]         r_dist;
    logic                  r_aim_done;
    logic [DW-1:0]         r_sf;
    logic [STAMP_BITS-1:0] r_best;
    logic [FW-1:0]         r_where;
    logic                  r_found;
    egd_pkg::t_out_item    r_result;

    logic [FW-1:0] here, tgt;
    logic [DW:0]   up_w;
    logic signed [DW:0] dn_w;
    logic up_ok, dn_ok, up_hit, dn_hit;
    logic [FW-1:0] sf_i;

    assign here = r_floor[r_car];
    assign tgt  = r_target[r_car];
    assign up_w = {1'b0, DW'(here)} + {1'b0, r_dist};
    assign dn_w = $signed({1'b0, DW'(here)}) - $signed({1'b0, r_dist});
    assign up_ok = up_w < (DW+1)'(FLOORS);
    assign dn_ok = !dn_w[DW];
    assign up_hit = up_ok && r_btn[r_car][up_w[FW-1:0]];
    assign dn_hit = dn_ok && r_btn[r_car][dn_w[FW-1:0]];
    assign sf_i = r_sf[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CARS; c++) begin
                r_floor[c]  <= '0;
                r_target[c] <= '0;
                r_btn[c]    <= '0;
            end
            for (int f = 0; f < FLOORS; f++) r_stamp[f] <= '0;
            r_door <= '0;
            r_cnt  <= '0;
            r_car  <= '0;
            r_aim_done <= 1'b0;
            r_found <= 1'b0;
            r_dist <= '0;
            r_sf <= '0;
        end else begin
            if (i_cmd.load) r_item <= i_item;
            if (i_cmd.do_button) begin
                if ({30'd0, r_item.car_index} < CARS && {28'd0, r_item.floor} < FLOORS)
                    r_btn[CW'(r_item.car_index)][FW'(r_item.floor)] <= 1'b1;
            end
            if (i_cmd.do_hall && {28'd0, r_item.floor} < FLOORS) begin
                if (r_cnt != SMAX) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_stamp[FW'(r_item.floor)] <= r_cnt + 1'b1;
                end else begin
                    r_stamp[FW'(r_item.floor)] <= r_cnt;
                end
            end
            if (i_cmd.clr_doors) r_door <= '0;
            if (i_cmd.serve) begin
                // open for an own button or a hall call here
                if (r_btn[r_car][here] || r_stamp[here] != '0) r_door[r_car] <= 1'b1;
                if (r_btn[r_car][here]) r_btn[r_car][here] <= 1'b0;
                if (r_stamp[here] != '0) r_stamp[here] <= '0;
            end
            if (i_cmd.aim_init) begin
                r_dist <= DW'(1);
                r_aim_done <= 1'b0;
                if (here == tgt) r_door[r_car] <= 1'b1;
            end
            if (i_cmd.aim_step) begin
                // nearest button, up first at each distance
                if (up_hit) begin
                    r_target[r_car] <= up_w[FW-1:0];
                    r_aim_done <= 1'b1;
                end else if (dn_hit) begin
                    r_target[r_car] <= dn_w[FW-1:0];
                    r_aim_done <= 1'b1;
                end else if ((!up_ok && !dn_ok) || r_dist >= DW'(FLOORS - 1)) begin
                    r_aim_done <= 1'b1;
                end
                r_dist <= r_dist + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_sf <= '0;
                r_best <= r_cnt;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (r_stamp[sf_i] != '0 && r_stamp[sf_i] <= r_best) begin
                    r_best <= r_stamp[sf_i];
                    r_where <= sf_i;
                    r_found <= 1'b1;
                end
                r_sf <= r_sf + 1'b1;
            end
            if (i_cmd.assign_c) begin
                r_stamp[r_where] <= '0;
                r_target[r_car] <= r_where;
            end
            if (i_cmd.move && !r_door[r_car]) begin
                if (tgt > here) r_floor[r_car] <= here + 1'b1;
                else if (tgt < here) r_floor[r_car] <= here - 1'b1;
            end
            if (i_cmd.car_clr) r_car <= '0;
            else if (i_cmd.car_next) r_car <= r_car + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.car_id       <= egd_pkg::CAR_W'(r_car);
            r_result.car_floor    <= egd_pkg::FLOOR_W'(here);
            r_result.car_target   <= egd_pkg::FLOOR_W'(tgt);
            r_result.door_is_open <= r_door[r_car];
            r_result.last_car     <= ({1'b0, r_car} == (CW+1)'(CARS - 1));
        end
    end

    assign o_result = r_result;

    always_comb begin
        o_sts.is_button = r_item.func == egd_pkg::FUNC_BUTTON;
        o_sts.is_hall   = r_item.func == egd_pkg::FUNC_HALL;
        o_sts.is_step   = r_item.func == egd_pkg::FUNC_STEP;
        o_sts.car_last  = {1'b0, r_car} == (CW+1)'(CARS - 1);
        o_sts.at_target = here == tgt;
        o_sts.aim_done  = r_aim_done;
        o_sts.scan_done = r_sf == DW'(FLOORS);
        o_sts.found     = r_found;
    end
endmodule

// ----- rtl/core/egd_ctrl.sv -----
// ----------------------------------------------------------------------------
// egd_ctrl
// Sequencer for the step tick phases and the item handshake.
// ----------------------------------------------------------------------------
module egd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_strobe,
    output egd_pkg::t_cmd o_cmd,
    input  egd_pkg::t_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SERVE, S_AIM_INIT, S_AIM, S_AIM_NEXT,
        S_SCAN_CHK, S_SCAN, S_ASSIGN, S_MOVE, S_EMIT, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_strobe;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.do_button = i_sts.is_button;
                o_cmd.do_hall   = i_sts.is_hall;
                if (i_sts.is_step) begin
                    o_cmd.clr_doors = 1'b1;
                    o_cmd.car_clr = 1'b1;
                    n_state = S_SERVE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SERVE: begin
                o_cmd.serve = 1'b1;
                o_cmd.car_next = 1'b1;
                if (i_sts.car_last) begin
                    o_cmd.car_clr = 1'b1;
                    n_state = S_AIM_INIT;
                end
            end
            S_AIM_INIT: begin
                o_cmd.aim_init = 1'b1;
                n_state = i_sts.at_target ? S_AIM : S_AIM_NEXT;
            end
            S_AIM: begin
                if (i_sts.aim_done) n_state = S_AIM_NEXT;
                else o_cmd.aim_step = 1'b1;
            end
            S_AIM_NEXT: begin
                o_cmd.car_next = 1'b1;
                if (i_sts.car_last) begin
                    o_cmd.car_clr = 1'b1;
                    n_state = S_SCAN_CHK;
                end else begin
                    n_state = S_AIM_INIT;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.at_target) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end else if (i_sts.car_last) begin
                    o_cmd.car_clr = 1'b1;
                    n_state = S_MOVE;
                end else begin
                    o_cmd.car_next = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_ASSIGN;
                else o_cmd.scan_step = 1'b1;
            end
            S_ASSIGN: begin
                // drop remaining cars once nothing is waiting
                if (!i_sts.found || i_sts.car_last) begin
                    o_cmd.assign_c = i_sts.found;
                    o_cmd.car_clr = 1'b1;
                    n_state = S_MOVE;
                end else begin
                    o_cmd.assign_c = 1'b1;
                    o_cmd.car_next = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.car_next = 1'b1;
                n_state = i_sts.car_last ? S_DONE : S_MOVE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_state != S_IDLE;
            r_strobe <= o_cmd.emit;
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;
endmodule

// ----- rtl/core/elevator_group_dispatch.sv -----
// ----------------------------------------------------------------------------
// elevator_group_dispatch
// Lift group controller: buttons, hall requests and a stepped dispatcher.
// ----------------------------------------------------------------------------
// Raise start with an item while busy is low. A step tick runs serve, aim,
// dispatch and move phases car by car, with a nearest-button search by
// distance and an oldest-request scan over the floors. It emits one result
// per car on o_valid, one cycle each; the receiver cannot stall, so results
// must be taken when the strobe is high.
// ----------------------------------------------------------------------------
module elevator_group_dispatch #(
    parameter int FLOORS     = egd_pkg::FLOORS_DEF,
    parameter int CARS       = egd_pkg::CARS_DEF,
    parameter int STAMP_BITS = egd_pkg::STAMP_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  egd_pkg::t_in_item  i_item,
    output logic               o_valid,
    output egd_pkg::t_out_item o_result
);
    egd_pkg::t_cmd cmd;
    egd_pkg::t_sts sts;

    egd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .o_strobe(o_valid), .o_cmd(cmd), .i_sts(sts)
    );

    egd_datapath #(.FLOORS(FLOORS), .CARS(CARS), .STAMP_BITS(STAMP_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(cmd),
        .o_sts(sts), .o_result(o_result)
    );
endmodule

// ----- tb/tb_dispatch_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dispatch_checker
// Watches item transfers into the lift dispatcher, predicts each step's car
// reports and compares them field by field with the reported results.
// ----------------------------------------------------------------------------
module tb_dispatch_checker
    import egd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  logic      busy,
    input  t_in_item  i_item,
    input  logic      o_valid,
    input  t_out_item o_result,
    output int        fail_count,
    output int        pending,
    output int        steps_seen,
    output int        reports_seen
);

    localparam int NF = FLOORS_DEF;
    localparam int NC = CARS_DEF;
    localparam logic [15:0] STAMP_TOP = 16'hFFFF;

    logic [3:0]  car_at   [NC];
    logic [3:0]  car_goal [NC];
    logic        door     [NC];
    logic [15:0] buttons  [NC];
    logic [15:0] stamp    [NF];
    logic [15:0] req_count;

    t_out_item car_reports [$];

    function automatic int oldest_hall();
        logic [15:0] best;
        int where;
        best  = req_count;
        where = -1;
        for (int f = 0; f < NF; f++) begin
            if (stamp[f] != 0 && stamp[f] <= best) begin
                best  = stamp[f];
                where = f;
            end
        end
        return where;
    endfunction

    task automatic dispatch_step();
        int here, up, dn, f;
        bit done;
        t_out_item r;
        for (int c = 0; c < NC; c++) door[c] = 1'b0;
        for (int c = 0; c < NC; c++) begin
            here = car_at[c];
            if (buttons[c][here]) begin
                door[c] = 1'b1;
                buttons[c][here] = 1'b0;
            end
            if (stamp[here] != 0) begin
                stamp[here] = '0;
                door[c] = 1'b1;
            end
        end
        for (int c = 0; c < NC; c++) begin
            if (car_at[c] == car_goal[c]) begin
                door[c] = 1'b1;
                here = car_at[c];
                done = 0;
                for (int d = 1; d < NF && !done; d++) begin
                    up = here + d;
                    dn = here - d;
                    if (up < NF && buttons[c][up]) begin
                        car_goal[c] = up[3:0];
                        done = 1;
                    end else if (dn >= 0 && buttons[c][dn]) begin
                        car_goal[c] = dn[3:0];
                        done = 1;
                    end
                end
            end
        end
        done = 0;
        for (int c = 0; c < NC && !done; c++) begin
            if (car_goal[c] == car_at[c]) begin
                f = oldest_hall();
                if (f < 0) done = 1;
                else begin
                    stamp[f] = '0;
                    car_goal[c] = f[3:0];
                end
            end
        end
        for (int c = 0; c < NC; c++) begin
            if (!door[c]) begin
                if (car_goal[c] > car_at[c]) car_at[c] = car_at[c] + 1'b1;
                else if (car_goal[c] < car_at[c]) car_at[c] = car_at[c] - 1'b1;
            end
        end
        for (int c = 0; c < NC; c++) begin
            r.car_id       = c[1:0];
            r.car_floor    = car_at[c];
            r.car_target   = car_goal[c];
            r.door_is_open = door[c];
            r.last_car     = (c == NC - 1);
            car_reports.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int c = 0; c < NC; c++) begin
                car_at[c] = '0; car_goal[c] = '0; door[c] = 1'b0; buttons[c] = '0;
            end
            for (int f = 0; f < NF; f++) stamp[f] = '0;
            req_count = '0;
            car_reports.delete();
            fail_count   <= 0;
            steps_seen   <= 0;
            reports_seen <= 0;
        end else begin
            if (o_valid) begin
                reports_seen <= reports_seen + 1;
                if (car_reports.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected car report %p", o_result);
                    fail_count <= fail_count + 1;
                end else begin
                    want = car_reports.pop_front();
                    if (want !== o_result) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, o_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                case (i_item.func)
                    FUNC_BUTTON: buttons[i_item.car_index][i_item.floor] = 1'b1;
                    FUNC_HALL: begin
                        if (req_count != STAMP_TOP) req_count = req_count + 1'b1;
                        stamp[i_item.floor] = req_count;
                    end
                    FUNC_STEP: begin
                        dispatch_step();
                        steps_seen <= steps_seen + 1;
                    end
                    default: ;
                endcase
            end
        end
        pending = car_reports.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random button, hall and step items into the lift
// dispatcher in random bursts; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    import egd_pkg::*;

    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_result;
    int        fail_count, pending, steps_seen, reports_seen;
    int        cycles;

    elevator_group_dispatch u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    tb_dispatch_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .fail_count(fail_count), .pending(pending),
        .steps_seen(steps_seen), .reports_seen(reports_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    int burst_left;

    // Hold the item until it is taken; between bursts, idle for a random gap that may be empty.
    task automatic send_item(input logic [1:0] fn, input logic [1:0] car,
                             input logic [3:0] fl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= '{func: fn, car_index: car, floor: fl};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0] fn;
        int pick;
        start      = 1'b0;
        i_item     = '0;
        i_rst_n    = 1'b0;
        burst_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme floors and cars, hall calls and the ignored code.
        send_item(FUNC_STEP, 2'd0, 4'd0);
        send_item(FUNC_BUTTON, 2'd0, 4'd15);
        send_item(FUNC_BUTTON, 2'd3, 4'd0);
        send_item(FUNC_BUTTON, 2'd1, 4'd2);
        send_item(FUNC_BUTTON, 2'd1, 4'd0);
        send_item(FUNC_BUTTON, 2'd2, 4'd1);
        send_item(FUNC_HALL, 2'd3, 4'd15);
        send_item(FUNC_HALL, 2'd0, 4'd7);
        send_item(FUNC_UNUSED, 2'd3, 4'd15);
        send_item(FUNC_STEP, 2'd1, 4'd0);
        send_item(FUNC_BUTTON, 2'd0, 4'd0);
        send_item(FUNC_STEP, 2'd3, 4'd15);
        send_item(FUNC_HALL, 2'd0, 4'd0);
        send_item(FUNC_STEP, 2'd0, 4'd0);
        for (int i = 0; i < 6; i++) send_item(FUNC_STEP, 2'd2, 4'd9);

        // Random: mostly buttons and halls, steps often enough to move cars.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            fn = (pick < 30) ? FUNC_BUTTON : (pick < 55) ? FUNC_HALL :
                 (pick < 96) ? FUNC_STEP : FUNC_UNUSED;
            send_item(fn, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        end

        // Run the cars out, then a couple of fresh hall calls.
        for (int i = 0; i < 30; i++) send_item(FUNC_STEP, 2'd0, 4'd0);
        send_item(FUNC_HALL, 2'd1, 4'd5);
        send_item(FUNC_HALL, 2'd1, 4'd3);
        for (int i = 0; i < 8; i++) send_item(FUNC_STEP, 2'd0, 4'd0);
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d steps and %0d car reports over directed and random items",
                 steps_seen, reports_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/egd_pkg.sv
rtl/core/egd_datapath.sv
rtl/core/egd_ctrl.sv
rtl/core/elevator_group_dispatch.sv
tb/tb_dispatch_checker.sv
tb/tb_top.sv
